[rtl/trd_pkg.sv]
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the run-length pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Configuration register indexes.
  localparam logic CFG_ALPHA_PRESENT = 1'b0;
  localparam logic CFG_PIXEL_TOTAL   = 1'b1;

  localparam int CFG_DATA_W = 32;

  // Packet header fields.
  localparam int HDR_RUN_BIT = 7;

  // Width of a packet pixel count (1 to 128 pixels).
  localparam int PKT_CNT_W = 9;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } trd_in_word_t;

  typedef struct packed {
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic [7:0] alpha_a;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
    logic [7:0] alpha_b;
    logic       second_valid;
    logic       last_of_run;
    logic       frame_done;
    logic       overflow_error;
  } trd_out_word_t;

  // One completed pixel and how many copies of it the back must emit.
  // A count of zero marks a pixel that arrived with nothing left to decode.
  typedef struct packed {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic [PKT_CNT_W-1:0] count;
    logic                 done;
    logic                 overflow;
  } trd_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } trd_q_status_t;

endpackage

[rtl/trd_front.sv]
// ----------------------------------------------------------------------------
// trd_front
// Takes stream bytes, parses packet headers, assembles pixels and keeps the
// frame pixel count; each completed pixel becomes one job for the back.
// ----------------------------------------------------------------------------
module trd_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  trd_pkg::trd_in_word_t in_word,
  input  logic                  alpha_present,
  input  logic [COUNT_WIDTH-1:0] pixel_total,
  input  trd_pkg::trd_q_status_t q_status,
  output logic                  push,
  output trd_pkg::trd_job_t     job
);
  import trd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > PKT_CNT_W) ? COUNT_WIDTH : PKT_CNT_W;

  logic                   expect_r, expect_nxt;
  logic                   run_r, run_nxt;
  logic [PKT_CNT_W-1:0]   left_r, left_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic [23:0]            held_r, held_nxt;
  logic [COUNT_WIDTH-1:0] decoded_r, decoded_nxt;
  logic                   stopped_r, stopped_nxt;

  logic                   accept;
  logic                   cur_expect, cur_run, cur_stopped;
  logic [PKT_CNT_W-1:0]   cur_left, left_eff, n_req, n_sel;
  logic [1:0]             cur_pos, last_pos;
  logic [23:0]            cur_held;
  logic [COUNT_WIDTH-1:0] cur_decoded, remaining;
  logic [CMP_W-1:0]       rem_ext, n_req_ext, left_ext;
  logic [7:0]             b;
  logic                   done, err;

  assign in_stall = q_status.full;
  assign accept   = in_valid & ~in_stall;
  assign b        = in_word.data_byte;

  always_comb begin
    // A frame start clears the frame state before its byte is taken.
    cur_expect  = in_word.frame_start | expect_r;
    cur_run     = in_word.frame_start ? 1'b0 : run_r;
    cur_left    = in_word.frame_start ? '0 : left_r;
    cur_pos     = in_word.frame_start ? 2'd0 : pos_r;
    cur_held    = in_word.frame_start ? '0 : held_r;
    cur_decoded = in_word.frame_start ? '0 : decoded_r;
    cur_stopped = in_word.frame_start ? 1'b0 : stopped_r;

    last_pos  = alpha_present ? 2'd3 : 2'd2;
    remaining = (cur_decoded < pixel_total) ? (pixel_total - cur_decoded) : '0;
    left_eff  = (cur_left == '0) ? PKT_CNT_W'(1) : cur_left;
    n_req     = cur_run ? left_eff : PKT_CNT_W'(1);
    rem_ext   = CMP_W'(remaining);
    n_req_ext = CMP_W'(n_req);
    left_ext  = CMP_W'(left_eff);
    n_sel     = (n_req_ext > rem_ext) ? PKT_CNT_W'(rem_ext) : n_req;
    err       = (n_sel == '0);
    // The count never passes the total, so the frame is done exactly when
    // this pixel uses up what remained.
    done      = (CMP_W'(n_sel) == rem_ext);

    job.blue     = cur_held[7:0];
    job.green    = cur_held[15:8];
    job.red      = alpha_present ? cur_held[23:16] : b;
    job.alpha    = alpha_present ? b : 8'd0;
    job.count    = n_sel;
    job.done     = done;
    job.overflow = (left_ext > rem_ext);

    expect_nxt  = cur_expect;
    run_nxt     = cur_run;
    left_nxt    = cur_left;
    pos_nxt     = cur_pos;
    held_nxt    = cur_held;
    decoded_nxt = cur_decoded;
    stopped_nxt = cur_stopped;
    push        = 1'b0;

    if (!cur_stopped) begin
      if (cur_expect) begin
        run_nxt    = b[HDR_RUN_BIT];
        left_nxt   = b[HDR_RUN_BIT] ? (PKT_CNT_W'(b[6:0]) + PKT_CNT_W'(1))
                                    : (PKT_CNT_W'(b) + PKT_CNT_W'(1));
        pos_nxt    = 2'd0;
        held_nxt   = '0;
        expect_nxt = 1'b0;
      end else if (cur_pos < last_pos) begin
        case (cur_pos)
          2'd0:    held_nxt[7:0]   = b;
          2'd1:    held_nxt[15:8]  = b;
          2'd2:    held_nxt[23:16] = b;
          default: held_nxt        = cur_held;
        endcase
        pos_nxt = cur_pos + 2'd1;
      end else begin
        push        = 1'b1;
        pos_nxt     = 2'd0;
        held_nxt    = '0;
        decoded_nxt = cur_decoded + COUNT_WIDTH'(n_sel);
        stopped_nxt = err | done;
        if (cur_run) begin
          left_nxt   = '0;
          expect_nxt = 1'b1;
        end else begin
          left_nxt   = left_eff - PKT_CNT_W'(1);
          expect_nxt = (left_eff == PKT_CNT_W'(1));
        end
      end
    end

    push = push & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r  <= 1'b1;
      run_r     <= 1'b0;
      left_r    <= '0;
      pos_r     <= 2'd0;
      held_r    <= '0;
      decoded_r <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      expect_r  <= expect_nxt;
      run_r     <= run_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
      held_r    <= held_nxt;
      decoded_r <= decoded_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("front pushed a job into a full queue");

  a_decoded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push && !in_word.frame_start && (decoded_r < pixel_total)
      |=> decoded_r <= $past(pixel_total))
    else $error("pixel count passed the frame total");

endmodule

[rtl/trd_queue.sv]
// ----------------------------------------------------------------------------
// trd_queue
// Short first-in first-out queue of pixel jobs between front and back.
// ----------------------------------------------------------------------------
module trd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  trd_pkg::trd_job_t      push_job,
  input  logic                   pop,
  output trd_pkg::trd_job_t      head_job,
  output trd_pkg::trd_q_status_t status
);
  import trd_pkg::*;

  trd_job_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign status.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count beyond its depth");

endmodule

[rtl/trd_back.sv]
// ----------------------------------------------------------------------------
// trd_back
// Expands each pixel job into result words, up to two pixels per word, and
// holds the current word in an output register until it is taken.
// ----------------------------------------------------------------------------
module trd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  trd_pkg::trd_job_t      head_job,
  input  trd_pkg::trd_q_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output trd_pkg::trd_out_word_t out_word
);
  import trd_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  trd_out_word_t        out_word_r, word_nxt;
  logic [PKT_CNT_W-1:0] sent_r, sent_nxt, rem;
  logic                 slot_free, fire, err, second, last;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign fire      = ~q_status.empty & slot_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    rem    = head_job.count - sent_r;
    err    = (head_job.count == '0);
    second = ~err & (rem >= PKT_CNT_W'(2));
    last   = err | (rem <= PKT_CNT_W'(2));

    word_nxt.red_a          = err ? 8'd0 : head_job.red;
    word_nxt.green_a        = err ? 8'd0 : head_job.green;
    word_nxt.blue_a         = err ? 8'd0 : head_job.blue;
    word_nxt.alpha_a        = err ? 8'd0 : head_job.alpha;
    word_nxt.red_b          = second ? head_job.red : 8'd0;
    word_nxt.green_b        = second ? head_job.green : 8'd0;
    word_nxt.blue_b         = second ? head_job.blue : 8'd0;
    word_nxt.alpha_b        = second ? head_job.alpha : 8'd0;
    word_nxt.second_valid   = second;
    word_nxt.last_of_run    = last;
    word_nxt.frame_done     = last & (err | head_job.done);
    word_nxt.overflow_error = last & (err | head_job.overflow);

    pop = fire & last;
    if (pop) begin
      sent_nxt = '0;
    end else if (fire) begin
      sent_nxt = sent_r + PKT_CNT_W'(2);
    end else begin
      sent_nxt = sent_r;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
  end

  a_sent_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (sent_r != '0) |-> !q_status.empty)
    else $error("partial run count with no job at the queue head");

  a_sent_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !last |=> sent_r == $past(sent_r) + PKT_CNT_W'(2))
    else $error("run expansion did not advance by two pixels");

endmodule

[rtl/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length pixel stream decoder: bytes in, R,G,B,A result words out.
// ----------------------------------------------------------------------------
// Usage: bytes of the compressed pixel stream enter on the in_ channel, one
// word per byte, with frame_start set on the first byte of each image. A word
// moves when its valid is high and the receiver's stall is low. The cfg_
// channel writes alpha_present (index 0) and pixel_total (index 1) and is
// always ready. The user must write it only while the decoder is idle; the
// block itself does not enforce this. Header bytes and bytes that do not
// finish a pixel give no result. A byte that finishes a literal pixel gives
// one result word; one that finishes a run pixel gives (copies + 1) / 2
// words of up to two pixels each, the last carrying last_of_run, frame_done
// and overflow_error. A finishing byte's job goes from the front into the
// job queue, then from the queue head into the output register.
// Throughput is one byte per cycle while the job queue has room and one
// result word per cycle while the receiver does not stall, set by the back's
// single output register; input stalls once the two-entry queue is full.
// Reset empties the queue and the output register, sets alpha_present to 0
// and pixel_total to 1, and leaves the decoder waiting for a packet header.
// While the receiver stalls, the output word holds and the queue fills.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  trd_pkg::trd_in_word_t             in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output trd_pkg::trd_out_word_t            out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import trd_pkg::*;

  // Configuration registers.
  logic                   alpha_present_r;
  logic [COUNT_WIDTH-1:0] pixel_total_r;

  // Front to queue and queue to back.
  logic          push, pop;
  trd_job_t      push_job, head_job;
  trd_q_status_t q_status;

  // The register file never needs to hold off a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_present_r <= 1'b0;
      pixel_total_r   <= COUNT_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA_PRESENT: alpha_present_r <= cfg_data[0];
        CFG_PIXEL_TOTAL:   pixel_total_r   <= cfg_data[COUNT_WIDTH-1:0];
        default:           alpha_present_r <= alpha_present_r;
      endcase
    end
  end

  // The front parses headers and assembles pixels; it stalls input only when
  // the job queue is full.
  trd_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .alpha_present (alpha_present_r),
    .pixel_total   (pixel_total_r),
    .q_status      (q_status),
    .push          (push),
    .job           (push_job)
  );

  // The queue lets a long run expand at the back while the front keeps
  // taking bytes.
  trd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // The back emits result words from the job at the queue head.
  trd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[tb/tga_rle_decode_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_decode_checker
// Watches the byte, result and register channels of the run-length pixel
// decoder, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module tga_rle_decode_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  trd_pkg::trd_in_word_t         in_word,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  trd_pkg::trd_out_word_t        out_word,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            words_owed,
  output int                            bytes_live,
  output int                            words_checked
);
  import trd_pkg::*;

  // Register copies.
  logic        alpha_on;
  logic [31:0] total_cfg;

  // Decoder state as the stream defines it.
  logic        want_header;
  logic        run_pkt;
  int unsigned pkt_left;
  logic [1:0]  pos;
  logic [23:0] held;
  logic [31:0] decoded;
  logic        halted;

  trd_out_word_t pixel_words_due[$];

  task automatic clear_frame();
    want_header = 1'b1;
    run_pkt     = 1'b0;
    pkt_left    = 0;
    pos         = 2'd0;
    held        = 24'd0;
    decoded     = 32'd0;
    halted      = 1'b0;
  endtask

  // Takes one accepted byte and queues the result words it must cause.
  task automatic decode_byte(input logic [7:0] b, input logic fresh);
    logic [1:0]  final_pos;
    logic [7:0]  red, green, blue, alpha;
    logic [31:0] room;
    int unsigned left, n, words, k;
    trd_out_word_t w;
    if (fresh) clear_frame();
    if (halted) return;
    bytes_live++;
    if (want_header) begin
      run_pkt     = b[HDR_RUN_BIT];
      pkt_left    = run_pkt ? int'(b[6:0]) + 1 : int'(b) + 1;
      pos         = 2'd0;
      held        = 24'd0;
      want_header = 1'b0;
      return;
    end
    final_pos = alpha_on ? 2'd3 : 2'd2;
    if (pos < final_pos) begin
      held[8*pos +: 8] = b;
      pos = pos + 2'd1;
      return;
    end
    pos   = 2'd0;
    blue  = held[7:0];
    green = held[15:8];
    if (alpha_on) begin
      red   = held[23:16];
      alpha = b;
    end else begin
      red   = b;
      alpha = 8'd0;
    end
    room = (decoded < total_cfg) ? total_cfg - decoded : 32'd0;
    left = (pkt_left != 0) ? pkt_left : 1;
    n    = run_pkt ? left : 1;
    if (n > room) n = room;

    // A pixel with nothing left to decode gives one all-zero flagged word.
    if (n == 0) begin
      w = '0;
      w.last_of_run    = 1'b1;
      w.frame_done     = 1'b1;
      w.overflow_error = 1'b1;
      pixel_words_due.insert(pixel_words_due.size(), w);
      halted = 1'b1;
      return;
    end

    decoded = decoded + n;
    words   = (n + 1) / 2;
    for (k = 0; k < words; k++) begin
      w = '0;
      w.red_a   = red;
      w.green_a = green;
      w.blue_a  = blue;
      w.alpha_a = alpha;
      if (2 * k + 1 < n) begin
        w.red_b        = red;
        w.green_b      = green;
        w.blue_b       = blue;
        w.alpha_b      = alpha;
        w.second_valid = 1'b1;
      end
      if (k == words - 1) begin
        w.last_of_run    = 1'b1;
        w.frame_done     = (decoded >= total_cfg);
        w.overflow_error = (left > room);
      end
      pixel_words_due.insert(pixel_words_due.size(), w);
    end
    if (decoded >= total_cfg) halted = 1'b1;
    if (run_pkt) begin
      pkt_left    = 0;
      want_header = 1'b1;
    end else begin
      pkt_left = left - 1;
      if (pkt_left == 0) want_header = 1'b1;
    end
    held = 24'd0;
  endtask

  task automatic check_field(input string label, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    trd_out_word_t want;
    if (!rst_n) begin
      alpha_on = 1'b0;
      total_cfg = 32'd1;
      clear_frame();
      pixel_words_due.delete();
      fail_count = 0;
      words_owed = 0;
      bytes_live = 0;
      words_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA_PRESENT: alpha_on = cfg_data[0];
          CFG_PIXEL_TOTAL:   total_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(in_word.data_byte, in_word.frame_start);
      if (out_valid && !out_stall) begin
        if (pixel_words_due.size() == 0) begin
          $display("%0t: result word %h arrived with none expected", $time, out_word);
          fail_count++;
        end else begin
          want = pixel_words_due.pop_front();
          check_field("red_a", want.red_a, out_word.red_a);
          check_field("green_a", want.green_a, out_word.green_a);
          check_field("blue_a", want.blue_a, out_word.blue_a);
          check_field("alpha_a", want.alpha_a, out_word.alpha_a);
          check_field("red_b", want.red_b, out_word.red_b);
          check_field("green_b", want.green_b, out_word.green_b);
          check_field("blue_b", want.blue_b, out_word.blue_b);
          check_field("alpha_b", want.alpha_b, out_word.alpha_b);
          check_field("second_valid", want.second_valid, out_word.second_valid);
          check_field("last_of_run", want.last_of_run, out_word.last_of_run);
          check_field("frame_done", want.frame_done, out_word.frame_done);
          check_field("overflow_error", want.overflow_error, out_word.overflow_error);
          words_checked++;
        end
      end
      words_owed = pixel_words_due.size();
    end
  end

endmodule

[tb/tb_tga_rle_pixel_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder
// Drives compressed pixel streams into the run-length decoder and reports
// the verdict of the checker that sits beside it.
// ----------------------------------------------------------------------------
// A directed opening covers the longest run, single copies, literal pixels,
// a packet cut short by the pixel total, bytes after the frame has stopped,
// a pixel arriving after the total was lowered under the decoded count, and
// a change of pixel size in the middle of a pixel. Random phases follow:
// each waits for the decoder to drain, rewrites the registers at random and
// streams well-formed packets with a little noise and random restarts.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;
  import trd_pkg::*;

  localparam logic [31:0] MAX_TOTAL    = 32'hFFFE_0001;
  localparam int          BYTE_GOAL    = 410;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          IDLE_LIMIT   = 2000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  trd_in_word_t  in_word = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  trd_out_word_t out_word;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_index = CFG_ALPHA_PRESENT;
  logic [31:0]   cfg_data = 32'd0;

  int fail_count, words_owed, bytes_live, words_checked;

  // Pacing of both sides; a calm side never idles.
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  logic [4:0] stall_left = 5'd0;

  // Packet stream generator state. It follows the packet layout that the
  // stimulus intends; the decoder may see it differently after noise.
  bit          alpha_now = 1'b0;
  bit          start_frame_next = 1'b0;
  bit          hdr_due = 1'b1;
  int unsigned pix_left = 0;
  int unsigned bytes_left = 0;

  int reg_writes = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;

  always #2 clk = ~clk;

  tga_rle_pixel_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_decode_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_owed    (words_owed),
    .bytes_live    (bytes_live),
    .words_checked (words_checked)
  );

  // Receiver: after each accepted result word, hold stall for a drawn number
  // of cycles. out_stall is high exactly while the countdown is nonzero.
  always @(posedge clk) begin
    logic [4:0] next_left;
    if (!rst_n) begin
      stall_left <= 5'd0;
      out_stall  <= 1'b0;
    end else begin
      if (stall_left != 0) begin
        next_left = stall_left - 5'd1;
      end else if (out_valid && !out_stall) begin
        next_left = out_calm ? 5'd0 : 5'($urandom_range(0, 19));
      end else begin
        next_left = 5'd0;
      end
      stall_left <= next_left;
      out_stall  <= (next_left != 0);
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles at %0t", IDLE_LIMIT, $time);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one byte after a drawn gap and holds it until accepted. The
  // stall is looked at mid-cycle, where it is settled for the coming edge.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    logic took;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_word.data_byte     <= b;
    in_word.frame_start   <= fs;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
  endtask

  // Writes one register. The valid stays high so back-to-back writes need no
  // gap; whatever comes next lowers it.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    if (idx == CFG_ALPHA_PRESENT) alpha_now = val[0];
    reg_writes++;
  endtask

  // Waits until every expected word has come out, then lets the decoder's
  // pipeline empty of bytes that cause no result.
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Produces the next byte of the packet stream: headers with mostly short
  // counts, pixel bytes biased toward the extremes, and now and then a stray
  // byte or a fresh frame.
  task automatic next_stream_byte(output logic [7:0] b, output logic fs);
    int unsigned cnt;
    bit is_run;
    fs = 1'b0;
    if (start_frame_next || $urandom_range(0, 99) < 4) begin
      start_frame_next = 1'b0;
      fs = 1'b1;
      hdr_due = 1'b1;
    end
    if (!fs && $urandom_range(0, 99) < 4) begin
      b = 8'($urandom);
    end else if (hdr_due) begin
      is_run = 1'($urandom_range(0, 1));
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
      b = {is_run, cnt[6:0]};
      pix_left = is_run ? 1 : cnt + 1;
      bytes_left = 0;
      hdr_due = 1'b0;
    end else begin
      if (bytes_left == 0) bytes_left = alpha_now ? 4 : 3;
      case ($urandom_range(0, 9))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      bytes_left--;
      if (bytes_left == 0) begin
        pix_left--;
        if (pix_left == 0) hdr_due = 1'b1;
      end
    end
  endtask

  // One random phase: drain, maybe rewrite the registers, pick the pacing,
  // and stream a stretch of bytes. Some phases continue the previous frame,
  // so register changes land mid-packet and mid-pixel too.
  task automatic random_phase();
    logic [31:0] total;
    logic [7:0] b;
    logic fs;
    int len;
    settle();
    if ($urandom_range(0, 9) < 7) write_reg(CFG_ALPHA_PRESENT, 32'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0: total = 32'd1;
        1: total = MAX_TOTAL;
        2: total = $urandom_range(1, MAX_TOTAL);
        3: total = $urandom_range(41, 300);
        default: total = $urandom_range(2, 40);
      endcase
      write_reg(CFG_PIXEL_TOTAL, total);
    end
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) != 0) start_frame_next = 1'b1;
    len = $urandom_range(8, 40);
    repeat (len) begin
      next_stream_byte(b, fs);
      send_byte(b, fs);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Longest run (128 copies, 64 words), a single copy, a one-pixel literal.
    write_reg(CFG_ALPHA_PRESENT, 32'd0);
    write_reg(CFG_PIXEL_TOTAL, MAX_TOTAL);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);

    // Four-byte pixels: a run of four against a total of three overflows
    // and stops the frame; the byte after it must be dropped.
    settle();
    write_reg(CFG_ALPHA_PRESENT, 32'd1);
    write_reg(CFG_PIXEL_TOTAL, 32'd3);
    send_byte(8'h83, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h77, 1'b0);

    // Decode two pixels, then lower the total under the decoded count: the
    // next pixel finds nothing left and gives the all-flags word.
    settle();
    write_reg(CFG_PIXEL_TOTAL, 32'd10);
    send_byte(8'h81, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    settle();
    write_reg(CFG_PIXEL_TOTAL, 32'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hDD, 1'b0);

    // Three bytes of a four-byte pixel, then drop alpha: the fourth byte
    // finishes the pixel as red.
    settle();
    write_reg(CFG_PIXEL_TOTAL, MAX_TOTAL);
    send_byte(8'h00, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    settle();
    write_reg(CFG_ALPHA_PRESENT, 32'd0);
    send_byte(8'h44, 1'b0);

    // Random phases until the whole run has sent about the planned number
    // of bytes, directed ones included.
    settle();
    start_frame_next = 1'b1;
    while (bytes_sent < BYTE_GOAL) random_phase();

    settle();
    $display("Sent %0d bytes, %0d of them decoded, with %0d register writes.",
             bytes_sent, bytes_live, reg_writes);
    $display("Checked %0d result words against the predicted stream.", words_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/trd_pkg.sv
rtl/trd_front.sv
rtl/trd_queue.sv
rtl/trd_back.sv
rtl/tga_rle_pixel_decoder.sv
tb/tga_rle_decode_checker.sv
tb/tb_tga_rle_pixel_decoder.sv
